// ===== hw/rtl/scfc_pkg.sv =====
`timescale 1ns / 1ps

package scfc_pkg;

	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam int TEMP_SCALE  = 17500;
	localparam int TEMP_OFFSET = 4500;
	localparam int HUMID_SCALE = 10000;

	localparam int TEMP_PROD_W  = 31;
	localparam int HUMID_PROD_W = 30;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TEMP_BAD  = 2'd1,
		ST_HUMID_BAD = 2'd2
	} status_t;

	// byte position within a frame
	typedef enum logic [5:0] {
		B_T_MSB = 6'b000001,
		B_T_LSB = 6'b000010,
		B_T_CRC = 6'b000100,
		B_H_MSB = 6'b001000,
		B_H_LSB = 6'b010000,
		B_H_CRC = 6'b100000
	} pos_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] temp_raw;
		logic [15:0] raw_humid;
	} frame_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/sensor_frame_crc_check_convert_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Word                                                   Flag
// s_       in   tdata[7:0] rx_byte                                     tuser[0] frame_start
// m_       out  tdata[14:0] temp_centi, [28:15] humid_centi,           tuser[1:0] status
//               [44:29] raw_temp_word, [60:45] raw_humid_word
//
// One input word per cycle while s_tready is high; a result follows the sixth byte of a frame.
// m_tvalid rises once the frame has passed, in order, the queue (written at the edge
// that takes the sixth byte), the multiply stage and the divide-by-65535 output stage.
// The queue decouples the byte decoder from the scaling pipeline; s_tready
// drops only when the queue is full under sustained output stall.
// arst_n clears the byte position, CRC state and all valid flags.

module sensor_frame_crc_check_convert_core #(
	parameter int FifoDepth = scfc_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // temp_centi, humid_centi, raw_temp_word, raw_humid_word
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic              fire;
	logic              push;
	scfc_pkg::frame_t  push_data;
	logic              full;
	logic              pop;
	logic              not_empty;
	scfc_pkg::frame_t  pop_data;
	scfc_pkg::status_t status;
	logic [14:0]       temp_centi;
	logic [13:0]       humid_centi;
	logic [15:0]       raw_temp_word;
	logic [15:0]       raw_humid_word;

	assign s_tready = !full;
	assign fire     = s_tvalid && s_tready;

	scfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte    (s_tdata),
		.frame_start(s_tuser),
		.push       (push),
		.push_data  (push_data)
	);

	scfc_fifo #(
		.Depth(FifoDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.pop_data (pop_data)
	);

	scfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (not_empty),
		.in_data      (pop_data),
		.in_pop       (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (status),
		.out_temp     (temp_centi),
		.out_humid    (humid_centi),
		.out_raw_temp (raw_temp_word),
		.out_raw_humid(raw_humid_word)
	);

	assign m_tuser = status;
	assign m_tdata = {3'b000, raw_humid_word, raw_temp_word, humid_centi, temp_centi};

endmodule

// ===== hw/rtl/scfc_front.sv =====
`timescale 1ns / 1ps

module scfc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        rx_byte,
	input  logic              frame_start,
	output logic              push,
	output scfc_pkg::frame_t  push_data
);

	scfc_pkg::pos_t pos_q;
	scfc_pkg::pos_t pos;
	logic [7:0]     crc_q;
	logic [15:0]    temp_q;
	logic [15:0]    humid_q;
	logic           tgood_q;
	logic           hgood;

	assign pos = frame_start ? scfc_pkg::B_T_MSB : pos_q;
	assign hgood = (crc_q == rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= scfc_pkg::B_T_MSB;
			crc_q   <= scfc_pkg::CRC_INIT;
			temp_q  <= '0;
			humid_q <= '0;
			tgood_q <= 1'b0;
		end else if (fire) begin
			case (pos)
				scfc_pkg::B_T_LSB: begin
					crc_q  <= scfc_pkg::crc8_update(crc_q, rx_byte);
					temp_q <= {temp_q[15:8], rx_byte};
					pos_q  <= scfc_pkg::B_T_CRC;
				end
				scfc_pkg::B_T_CRC: begin
					tgood_q <= (crc_q == rx_byte);
					crc_q   <= scfc_pkg::CRC_INIT;
					pos_q   <= scfc_pkg::B_H_MSB;
				end
				scfc_pkg::B_H_MSB: begin
					crc_q   <= scfc_pkg::crc8_update(scfc_pkg::CRC_INIT, rx_byte);
					humid_q <= {rx_byte, 8'h00};
					pos_q   <= scfc_pkg::B_H_LSB;
				end
				scfc_pkg::B_H_LSB: begin
					crc_q   <= scfc_pkg::crc8_update(crc_q, rx_byte);
					humid_q <= {humid_q[15:8], rx_byte};
					pos_q   <= scfc_pkg::B_H_CRC;
				end
				scfc_pkg::B_H_CRC: begin
					crc_q <= scfc_pkg::CRC_INIT;
					pos_q <= scfc_pkg::B_T_MSB;
				end
				default: begin
					crc_q  <= scfc_pkg::crc8_update(scfc_pkg::CRC_INIT, rx_byte);
					temp_q <= {rx_byte, 8'h00};
					pos_q  <= scfc_pkg::B_T_LSB;
				end
			endcase
		end
	end

	assign push = fire && (pos == scfc_pkg::B_H_CRC);

	always_comb begin
		push_data.temp_raw  = temp_q;
		push_data.raw_humid = humid_q;
		if (!tgood_q) begin
			push_data.status = scfc_pkg::ST_TEMP_BAD;
		end else if (!hgood) begin
			push_data.status = scfc_pkg::ST_HUMID_BAD;
		end else begin
			push_data.status = scfc_pkg::ST_OK;
		end
	end

endmodule

// ===== hw/rtl/scfc_fifo.sv =====
`timescale 1ns / 1ps

module scfc_fifo #(
	parameter int Depth = scfc_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scfc_pkg::frame_t  push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output scfc_pkg::frame_t  pop_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	scfc_pkg::frame_t mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(Depth));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/scfc_back.sv =====
`timescale 1ns / 1ps

module scfc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  scfc_pkg::frame_t  in_data,
	output logic              in_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output scfc_pkg::status_t out_status,
	output logic [14:0]       out_temp,
	output logic [13:0]       out_humid,
	output logic [15:0]       out_raw_temp,
	output logic [15:0]       out_raw_humid
);

	localparam int TW = scfc_pkg::TEMP_PROD_W;
	localparam int HW = scfc_pkg::HUMID_PROD_W;

	// stage 1: scale products
	logic              valid_s1;
	scfc_pkg::frame_t  frame_s1;
	logic [TW-1:0]     tprod_s1;
	logic [HW-1:0]     hprod_s1;

	// stage 2: output register
	logic              valid_s2;
	scfc_pkg::status_t status_s2;
	logic [14:0]       temp_s2;
	logic [13:0]       humid_s2;
	logic [15:0]       rawt_s2;
	logic [15:0]       rawh_s2;

	logic              rdy_s2;
	logic              take_s1;
	logic [TW:0]       tsum;
	logic [HW:0]       hsum;
	logic [14:0]       tq;
	logic [13:0]       hq;
	logic [14:0]       tval;

	assign rdy_s2  = !valid_s2 || out_ready;
	assign take_s1 = !valid_s1 || rdy_s2;
	assign in_pop  = in_valid && take_s1;

	// floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for quotients below 2^16
	assign tsum = {1'b0, tprod_s1} + (TW + 1)'(tprod_s1 >> 16) + (TW + 1)'(1);
	assign hsum = {1'b0, hprod_s1} + (HW + 1)'(hprod_s1 >> 16) + (HW + 1)'(1);
	assign tq   = tsum[30:16];
	assign hq   = hsum[29:16];
	assign tval = tq - 15'(scfc_pkg::TEMP_OFFSET);

	always_ff @(posedge clk) begin
		if (in_pop) begin
			frame_s1 <= in_data;
			tprod_s1 <= TW'(in_data.temp_raw) * TW'(scfc_pkg::TEMP_SCALE);
			hprod_s1 <= HW'(in_data.raw_humid) * HW'(scfc_pkg::HUMID_SCALE);
		end
		if (valid_s1 && rdy_s2) begin
			status_s2 <= frame_s1.status;
			rawt_s2   <= frame_s1.temp_raw;
			rawh_s2   <= frame_s1.raw_humid;
			if (frame_s1.status == scfc_pkg::ST_OK) begin
				temp_s2  <= tval;
				humid_s2 <= hq;
			end else begin
				temp_s2  <= '0;
				humid_s2 <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign out_status    = status_s2;
	assign out_temp      = temp_s2;
	assign out_humid     = humid_s2;
	assign out_raw_temp  = rawt_s2;
	assign out_raw_humid = rawh_s2;

endmodule

// ===== hw/rtl/scfc_checker.sv =====
`timescale 1ns / 1ps

module scfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic signed [14:0] temp_centi;
	logic [13:0]        humid_centi;

	assign temp_centi  = m_tdata[14:0];
	assign humid_centi = m_tdata[28:15];

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input word changed under stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed under stall");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != scfc_pkg::ST_OK) |-> (m_tdata[28:0] == 29'd0))
		else $error("scaled fields not zero on CRC failure");

	a_humid_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == scfc_pkg::ST_OK) |-> (humid_centi <= 14'd10000))
		else $error("humidity out of range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == scfc_pkg::ST_OK) |->
		(temp_centi >= -15'sd4500) && (temp_centi <= 15'sd13000))
		else $error("temperature out of range");

endmodule

bind sensor_frame_crc_check_convert_core scfc_checker u_scfc_checker (.*);

// ===== sim/sensor_frame_checker.sv =====
`timescale 1ns / 1ps

module sensor_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // temp_centi, humid_centi, raw_temp_word, raw_humid_word
	input  logic [1:0]  m_tuser,   // [1:0] status
	output int          errors,
	output int          waiting
);

	typedef struct {
		scfc_pkg::status_t status;
		logic [14:0]       temp;
		logic [13:0]       humid;
		logic [15:0]       raw_t;
		logic [15:0]       raw_h;
	} reading_t;

	reading_t    readings[$];
	int unsigned pos;
	logic [7:0]  crc;
	logic [15:0] t_word;
	logic [15:0] h_word;
	logic        t_ok;

	function automatic logic [7:0] crc_next(logic [7:0] acc, logic [7:0] d);
		logic [7:0] r;
		r = acc ^ d;
		repeat (8) r = r[7] ? ((r << 1) ^ scfc_pkg::CRC_POLY) : (r << 1);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t    want;
		reading_t    r;
		logic        h_ok;
		int unsigned tq;
		int unsigned hq;
		if (!arst_n) begin
			pos = 0;
			crc = scfc_pkg::CRC_INIT;
			t_word = '0;
			h_word = '0;
			t_ok = 1'b0;
			readings.delete();
			waiting = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (readings.size() == 0) begin
					$error("result word with no reading expected");
					errors++;
				end else begin
					want = readings.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						errors++;
					end
					if (m_tdata[14:0] !== want.temp) begin
						$error("temp_centi: expected %0d, got %0d",
							$signed(want.temp), $signed(m_tdata[14:0]));
						errors++;
					end
					if (m_tdata[28:15] !== want.humid) begin
						$error("humid_centi: expected %0d, got %0d", want.humid, m_tdata[28:15]);
						errors++;
					end
					if (m_tdata[44:29] !== want.raw_t) begin
						$error("raw_temp_word: expected %h, got %h", want.raw_t, m_tdata[44:29]);
						errors++;
					end
					if (m_tdata[60:45] !== want.raw_h) begin
						$error("raw_humid_word: expected %h, got %h", want.raw_h, m_tdata[60:45]);
						errors++;
					end
					if (m_tdata[63:61] !== 3'b000) begin
						$error("tdata pad: expected 0, got %b", m_tdata[63:61]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser)
					pos = 0;
				case (pos)
					0: begin
						crc = crc_next(scfc_pkg::CRC_INIT, s_tdata);
						t_word = {s_tdata, 8'h00};
					end
					1: begin
						crc = crc_next(crc, s_tdata);
						t_word[7:0] = s_tdata;
					end
					2: begin
						t_ok = (crc == s_tdata);
						crc = scfc_pkg::CRC_INIT;
					end
					3: begin
						crc = crc_next(scfc_pkg::CRC_INIT, s_tdata);
						h_word = {s_tdata, 8'h00};
					end
					4: begin
						crc = crc_next(crc, s_tdata);
						h_word[7:0] = s_tdata;
					end
					default: begin
						h_ok = (crc == s_tdata);
						crc = scfc_pkg::CRC_INIT;
						r.status = !t_ok ? scfc_pkg::ST_TEMP_BAD :
							(!h_ok ? scfc_pkg::ST_HUMID_BAD : scfc_pkg::ST_OK);
						r.temp = '0;
						r.humid = '0;
						if (r.status == scfc_pkg::ST_OK) begin
							tq = (32'd17500 * {16'h0, t_word}) / 32'd65535;
							hq = (32'd10000 * {16'h0, h_word}) / 32'd65535;
							r.temp = 15'(tq - 32'd4500);
							r.humid = 14'(hq);
						end
						r.raw_t = t_word;
						r.raw_h = h_word;
						readings.push_back(r);
					end
				endcase
				pos = (pos >= 5) ? 0 : pos + 1;
			end
			waiting = readings.size();
		end
	end

endmodule

// ===== sim/tb_sensor_frame_crc_check_convert_core.sv =====
`timescale 1ns / 1ps

module tb_sensor_frame_crc_check_convert_core;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	int          errors;
	int          waiting;

	int          sent = 0;
	logic        no_gaps = 1'b0;
	logic        aligned = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sensor_frame_crc_check_convert_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sensor_frame_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.waiting  (waiting)
	);

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input logic [7:0] b, input logic start);
		int gap;
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
			input logic bad_t, input logic bad_h, input logic start);
		logic [7:0] ct;
		logic [7:0] ch;
		ct = scfc_pkg::crc8_update(scfc_pkg::crc8_update(scfc_pkg::CRC_INIT, t[15:8]), t[7:0]);
		ch = scfc_pkg::crc8_update(scfc_pkg::crc8_update(scfc_pkg::CRC_INIT, h[15:8]), h[7:0]);
		if (bad_t)
			ct ^= 8'($urandom_range(1, 255));
		if (bad_h)
			ch ^= 8'($urandom_range(1, 255));
		send_word(t[15:8], start);
		send_word(t[7:0], 1'b0);
		send_word(ct, 1'b0);
		send_word(h[15:8], 1'b0);
		send_word(h[7:0], 1'b0);
		send_word(ch, 1'b0);
		aligned = 1'b1;
	endtask

	function automatic logic [15:0] pick_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	initial begin
		int r;
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			r = $urandom_range(0, 9);
			n = (r < 3) ? 0 : idle_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		int r;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, frame wrap, partial-frame resync, bad CRC: both, humidity, temp
		send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_word(8'hAB, 1'b1);
		send_word(8'hCD, 1'b0);
		send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);
		send_frame(16'h1234, 16'hBEEF, 1'b0, 1'b1, 1'b0);
		send_frame(16'hA5A5, 16'h5A5A, 1'b1, 1'b0, 1'b1);

		while (sent < 1150) begin
			no_gaps = ($urandom_range(0, 99) < 15);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_frame(pick_word(), pick_word(), $urandom_range(0, 99) < 15,
					$urandom_range(0, 99) < 15, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
			end else if (r < 90) begin
				n = $urandom_range(1, 5);
				send_word(8'($urandom), 1'b1);
				repeat (n - 1) send_word(8'($urandom), 1'b0);
				aligned = 1'b0;
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) send_word(8'($urandom), $urandom_range(0, 3) == 0);
				aligned = 1'b0;
			end
		end
		s_tvalid <= 1'b0;

		while (waiting != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0 && waiting == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
